@@ sv/assert_macros.svh @@
// assertion macros shared by the scheduler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clk, held off while arst_n is low
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every rising edge of clk, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/cscan_pkg.sv @@
package cscan_pkg;

	// store geometry
	localparam int MAX_REQUESTS = 32;
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

	// field widths
	localparam int TRK_W = 12;
	localparam int SEEK_W = 14;

	localparam logic [TRK_W-1:0] TOP_TRACK_RESET = 12'd199;

	// input word kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [TRK_W-1:0] track_value;
		logic             direction_up;
	} in_item_t;

	typedef struct packed {
		logic [TRK_W-1:0]  served_track;
		logic              last_of_run;
		logic [SEEK_W-1:0] total_seek;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_TOTAL,
		ST_A_RD,
		ST_A_PUT,
		ST_END1,
		ST_END2,
		ST_B_RD,
		ST_B_PUT
	} state_t;

	// source of an emitted track
	typedef enum logic [1:0] {
		SEL_STORE,
		SEL_END1,
		SEL_END2
	} sel_t;

	typedef struct packed {
		logic load;       // append request to store
		logic start;      // latch head and direction, rewind pointer
		logic scan_step;  // entry not above head: remember it, advance
		logic scan_hit;   // entry above head: split found here
		logic calc;       // compute total, set up first sweep
		logic seg_b_init; // set up return sweep
		logic put;        // load output register
		sel_t put_sel;
		logic put_last;
		logic walk;       // step pointer along sweep, count down
	} cmd_t;

	typedef struct packed {
		logic scan_end;
		logic hit;
		logic rem_zero;
		logic rem_one;
		logic out_free;
	} status_t;

endpackage

@@ sv/cscan_ram.sv @@
module cscan_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/cscan_ctrl.sv @@
`include "assert_macros.svh"

module cscan_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	output logic               in_stall,
	input  cscan_pkg::status_t sts,
	output cscan_pkg::cmd_t    cmd
);

	cscan_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cscan_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cscan_pkg::ST_IDLE: begin
				if (in_valid && in_kind == cscan_pkg::KIND_START) begin
					state_d = cscan_pkg::ST_SRCH_RD;
				end
			end
			cscan_pkg::ST_SRCH_RD: begin
				state_d = sts.scan_end ? cscan_pkg::ST_TOTAL : cscan_pkg::ST_SRCH_CMP;
			end
			cscan_pkg::ST_SRCH_CMP: begin
				state_d = sts.hit ? cscan_pkg::ST_TOTAL : cscan_pkg::ST_SRCH_RD;
			end
			cscan_pkg::ST_TOTAL: begin
				state_d = cscan_pkg::ST_A_RD;
			end
			cscan_pkg::ST_A_RD: begin
				state_d = sts.rem_zero ? cscan_pkg::ST_END1 : cscan_pkg::ST_A_PUT;
			end
			cscan_pkg::ST_A_PUT: begin
				if (sts.out_free) begin
					state_d = cscan_pkg::ST_A_RD;
				end
			end
			cscan_pkg::ST_END1: begin
				if (sts.out_free) begin
					state_d = cscan_pkg::ST_END2;
				end
			end
			cscan_pkg::ST_END2: begin
				if (sts.out_free) begin
					state_d = sts.rem_zero ? cscan_pkg::ST_IDLE : cscan_pkg::ST_B_RD;
				end
			end
			cscan_pkg::ST_B_RD: begin
				state_d = cscan_pkg::ST_B_PUT;
			end
			cscan_pkg::ST_B_PUT: begin
				if (sts.out_free) begin
					state_d = sts.rem_one ? cscan_pkg::ST_IDLE : cscan_pkg::ST_B_RD;
				end
			end
			default: begin
				state_d = cscan_pkg::ST_IDLE;
			end
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd = '0;
		cmd.put_sel = cscan_pkg::SEL_STORE;
		in_stall = (state_q != cscan_pkg::ST_IDLE);
		unique case (state_q)
			cscan_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = (in_kind == cscan_pkg::KIND_LOAD);
					cmd.start = (in_kind == cscan_pkg::KIND_START);
				end
			end
			cscan_pkg::ST_SRCH_CMP: begin
				cmd.scan_hit = sts.hit;
				cmd.scan_step = !sts.hit;
			end
			cscan_pkg::ST_TOTAL: begin
				cmd.calc = 1'b1;
			end
			cscan_pkg::ST_A_PUT: begin
				cmd.put = sts.out_free;
				cmd.walk = sts.out_free;
			end
			cscan_pkg::ST_END1: begin
				cmd.put = sts.out_free;
				cmd.put_sel = cscan_pkg::SEL_END1;
				cmd.seg_b_init = sts.out_free;
			end
			cscan_pkg::ST_END2: begin
				cmd.put = sts.out_free;
				cmd.put_sel = cscan_pkg::SEL_END2;
				cmd.put_last = sts.rem_zero;
			end
			cscan_pkg::ST_B_PUT: begin
				cmd.put = sts.out_free;
				cmd.put_last = sts.rem_one;
				cmd.walk = sts.out_free;
			end
			default: begin
				cmd.put = 1'b0;
			end
		endcase
	end

	`ASSERT_RST(a_put_into_free_slot, cmd.put |-> sts.out_free, "word loaded over a waiting word")
	`ASSERT_RST(a_walk_in_segment, cmd.walk |-> !sts.rem_zero, "sweep stepped past its end")
	`ASSERT_RST(a_last_ends_run, (cmd.put && cmd.put_last) |=> state_q == cscan_pkg::ST_IDLE,
		"final word did not return controller to idle")

endmodule

@@ sv/cscan_dpath.sv @@
`include "assert_macros.svh"

module cscan_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cscan_pkg::TRK_W-1:0]         cfg_wdata,
	input  cscan_pkg::in_item_t                 in_data,
	input  logic                                out_stall,
	output logic                                out_valid,
	output cscan_pkg::out_item_t                out_data,
	input  cscan_pkg::cmd_t                     cmd,
	output cscan_pkg::status_t                  sts
);

	localparam int CW = cscan_pkg::CNT_W;
	localparam int IW = cscan_pkg::IDX_W;
	localparam int TW = cscan_pkg::TRK_W;
	localparam int SW = cscan_pkg::SEEK_W;

	logic [TW-1:0]        top_q;
	logic [CW-1:0]        count_q;
	logic [TW-1:0]        head_q;
	logic                 up_q;
	logic [CW-1:0]        ptr_q;
	logic [CW-1:0]        split_q;
	logic [CW-1:0]        rem_q;
	logic [TW-1:0]        prev_q;
	logic [TW-1:0]        hit_val_q;
	logic [SW-1:0]        total_q;
	logic                 out_valid_q;
	cscan_pkg::out_item_t out_q;

	logic          ram_we;
	logic [TW-1:0] rdata;
	logic [TW-1:0] dist_head;
	logic [TW-1:0] dist_hit;
	logic [SW-1:0] total_d;
	logic [CW-1:0] ptr_next;
	logic [TW-1:0] put_track;

	// request store
	assign ram_we = cmd.load && (count_q < CW'(cscan_pkg::MAX_REQUESTS));

	cscan_ram #(
		.WIDTH(TW),
		.DEPTH(cscan_pkg::MAX_REQUESTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[IW-1:0]),
		.wdata(in_data.track_value),
		.raddr(ptr_q[IW-1:0]),
		.rdata(rdata)
	);

	// top track register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= cscan_pkg::TOP_TRACK_RESET;
		end else if (cfg_we) begin
			top_q <= cfg_wdata;
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ram_we) begin
			count_q <= count_q + CW'(1);
		end
	end

	// seek total from head, split and its neighbors
	assign dist_head = (top_q >= head_q) ? (top_q - head_q) : (head_q - top_q);
	assign dist_hit = (top_q >= hit_val_q) ? (top_q - hit_val_q) : (hit_val_q - top_q);

	always_comb begin
		if (up_q) begin
			total_d = SW'(dist_head) + SW'(top_q)
				+ ((split_q != '0) ? SW'(prev_q) : '0);
		end else begin
			total_d = SW'(head_q) + SW'(top_q)
				+ ((split_q != count_q) ? SW'(dist_hit) : '0);
		end
	end

	assign ptr_next = up_q ? (ptr_q + CW'(1)) : (ptr_q - CW'(1));

	// scan and sweep registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			head_q <= in_data.track_value;
			up_q <= in_data.direction_up;
			ptr_q <= '0;
			split_q <= count_q;
		end
		if (cmd.scan_step) begin
			prev_q <= rdata;
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.scan_hit) begin
			split_q <= ptr_q;
			hit_val_q <= rdata;
		end
		if (cmd.calc) begin
			total_q <= total_d;
			ptr_q <= up_q ? split_q : (split_q - CW'(1));
			rem_q <= up_q ? (count_q - split_q) : split_q;
		end
		if (cmd.seg_b_init) begin
			ptr_q <= up_q ? '0 : (count_q - CW'(1));
			rem_q <= up_q ? split_q : (count_q - split_q);
		end
		if (cmd.walk) begin
			ptr_q <= ptr_next;
			rem_q <= rem_q - CW'(1);
		end
	end

	// track of the word being emitted
	always_comb begin
		unique case (cmd.put_sel)
			cscan_pkg::SEL_STORE: put_track = rdata;
			cscan_pkg::SEL_END1:  put_track = up_q ? top_q : '0;
			cscan_pkg::SEL_END2:  put_track = up_q ? '0 : top_q;
			default:              put_track = rdata;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			out_q.served_track <= put_track;
			out_q.last_of_run <= cmd.put_last;
			out_q.total_seek <= cmd.put_last ? total_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// status to the controller
	assign sts.scan_end = (ptr_q == count_q);
	assign sts.hit = (head_q < rdata);
	assign sts.rem_zero = (rem_q == '0);
	assign sts.rem_one = (rem_q == CW'(1));
	assign sts.out_free = !out_valid_q || !out_stall;

	`ASSERT_RST(a_count_bound, count_q <= CW'(cscan_pkg::MAX_REQUESTS), "fill count past store depth")
	`ASSERT_RST(a_split_bound, cmd.calc |-> split_q <= count_q, "split beyond filled entries")
	`ASSERT_RST(a_walk_in_store, cmd.walk |-> ptr_q < count_q, "sweep read outside filled entries")

endmodule

@@ sv/cscan_disk_scheduler_unit.sv @@
// load word: accepted when idle, no result; one load per cycle while idle
// start word: scan reads and compares each entry up to and including the first above the head
// (plus a final read when no entry lies above), then computes the total;
// then reads and emits each stored track, closes the first sweep, emits each end track; count+2 words;
// no new word is accepted until the last word sits in the output register
// reset: request count 0, top track 199, output empty; store contents stay undefined
module cscan_disk_scheduler_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cscan_pkg::TRK_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  cscan_pkg::in_item_t         in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output cscan_pkg::out_item_t        out_data
);

	cscan_pkg::cmd_t    cmd;
	cscan_pkg::status_t sts;

	// sequencing
	cscan_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_kind (in_data.kind),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// store, scan, totals and output register
	cscan_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

@@ verif/tb_cscan_disk_scheduler_unit.sv @@
`timescale 1ns / 100ps
module tb_cscan_disk_scheduler_unit;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 80;
	localparam int WORDS_PER_SEG = 41;

	// visiting order predictor and store of expected words
	class visit_order_board;
		logic [cscan_pkg::TRK_W-1:0]  top_track;
		logic [cscan_pkg::TRK_W-1:0]  store [cscan_pkg::MAX_REQUESTS];
		int                           count;
		int                           errors;
		int                           run_left;
		logic [cscan_pkg::SEEK_W-1:0] run_seek;
		cscan_pkg::out_item_t         expected_visits [$];

		function new();
			top_track = cscan_pkg::TOP_TRACK_RESET;
			count = 0;
			errors = 0;
		endfunction

		function int pending();
			return expected_visits.size();
		endfunction

		function int seek_gap(int a, int b);
			return (a >= b) ? a - b : b - a;
		endfunction

		// last word of a run carries the seek total
		function void add_visit(logic [cscan_pkg::TRK_W-1:0] trk);
			cscan_pkg::out_item_t v;
			run_left--;
			v.served_track = trk;
			v.last_of_run = (run_left == 0);
			v.total_seek = (run_left == 0) ? run_seek : '0;
			expected_visits.push_back(v);
		endfunction

		function void note_word(cscan_pkg::in_item_t w);
			int n, split, head, top, total;
			n = count;
			head = int'(w.track_value);
			top = int'(top_track);
			if (w.kind == cscan_pkg::KIND_LOAD) begin
				// full store drops the request
				if (n < cscan_pkg::MAX_REQUESTS) begin
					store[n] = w.track_value;
					count = n + 1;
				end
				return;
			end
			// first request strictly above the head
			split = n;
			for (int i = 0; i < n; i++) begin
				if (head < int'(store[i])) begin
					split = i;
					break;
				end
			end
			run_left = n + 2;
			if (w.direction_up) begin
				total = seek_gap(top, head) + top + ((split > 0) ? int'(store[split-1]) : 0);
				run_seek = total[cscan_pkg::SEEK_W-1:0];
				for (int i = split; i < n; i++)
					add_visit(store[i]);
				add_visit(top_track);
				add_visit('0);
				for (int i = 0; i < split; i++)
					add_visit(store[i]);
			end else begin
				total = head + top + ((split < n) ? seek_gap(top, int'(store[split])) : 0);
				run_seek = total[cscan_pkg::SEEK_W-1:0];
				for (int i = split; i > 0; i--)
					add_visit(store[i-1]);
				add_visit('0);
				add_visit(top_track);
				for (int i = n; i > split; i--)
					add_visit(store[i-1]);
			end
		endfunction

		function void check_visit(cscan_pkg::out_item_t got);
			cscan_pkg::out_item_t want;
			if (expected_visits.size() == 0) begin
				$error("unexpected word: served_track %0d", got.served_track);
				errors++;
				return;
			end
			want = expected_visits.pop_front();
			if (got.served_track !== want.served_track) begin
				$error("served_track: expected %0d, actual %0d",
					want.served_track, got.served_track);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, actual %0d",
					want.last_of_run, got.last_of_run);
				errors++;
			end
			if (got.total_seek !== want.total_seek) begin
				$error("total_seek: expected %0d, actual %0d",
					want.total_seek, got.total_seek);
				errors++;
			end
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [cscan_pkg::TRK_W-1:0] cfg_wdata;
	logic                        in_valid;
	logic                        in_stall;
	cscan_pkg::in_item_t         in_data;
	logic                        out_valid;
	logic                        out_stall;
	cscan_pkg::out_item_t        out_data;

	int               send_idle_pct;
	int               recv_idle_pct;
	int               quiet;
	visit_order_board board;

	cscan_disk_scheduler_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver stalls at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// accepted words on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_word(in_data);
			if (out_valid && !out_stall)
				board.check_visit(out_data);
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic cscan_pkg::in_item_t make_word(logic kind, int trk, logic up);
		cscan_pkg::in_item_t w;
		w.kind = kind;
		w.track_value = trk[cscan_pkg::TRK_W-1:0];
		w.direction_up = up;
		return w;
	endfunction

	// hold valid through stalls, idle gaps before the word
	task automatic send_word(input cscan_pkg::in_item_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// register write once the block has drained
	task automatic write_top(input logic [cscan_pkg::TRK_W-1:0] t);
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= t;
		board.top_track = t;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int seg, counted, head, next_track, top_pick;
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty store: only the two end tracks
		send_word(make_word(cscan_pkg::KIND_START, 0, 1'b1));
		send_word(make_word(cscan_pkg::KIND_START, 4095, 1'b0));
		// ascending loads, direction ignored
		send_word(make_word(cscan_pkg::KIND_LOAD, 0, 1'b1));
		send_word(make_word(cscan_pkg::KIND_LOAD, 37, 1'b0));
		send_word(make_word(cscan_pkg::KIND_LOAD, 120, 1'b1));
		send_word(make_word(cscan_pkg::KIND_LOAD, 199, 1'b0));
		send_word(make_word(cscan_pkg::KIND_LOAD, 4095, 1'b1));
		// head on a request, including the lowest and the highest
		send_word(make_word(cscan_pkg::KIND_START, 0, 1'b1));
		send_word(make_word(cscan_pkg::KIND_START, 120, 1'b0));
		send_word(make_word(cscan_pkg::KIND_START, 120, 1'b1));
		send_word(make_word(cscan_pkg::KIND_START, 4095, 1'b1));
		send_word(make_word(cscan_pkg::KIND_START, 4095, 1'b0));
		send_word(make_word(cscan_pkg::KIND_START, 0, 1'b0));
		send_word(make_word(cscan_pkg::KIND_START, 199, 1'b1));
		// out of order request
		send_word(make_word(cscan_pkg::KIND_LOAD, 10, 1'b0));
		send_word(make_word(cscan_pkg::KIND_START, 60, 1'b1));
		send_word(make_word(cscan_pkg::KIND_START, 60, 1'b0));
		send_word(make_word(cscan_pkg::KIND_START, 2, 1'b0));

		// random phases, two register settings per idle pattern
		next_track = 200;
		for (seg = 0; seg < 6; seg++) begin
			case (seg / 2)
				0: begin
					send_idle_pct = 33;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0: top_pick = 4095;
				1: top_pick = 1;
				3: top_pick = 199;
				5: top_pick = 4095;
				default: top_pick = $urandom_range(4095, 1);
			endcase
			write_top(top_pick[cscan_pkg::TRK_W-1:0]);
			counted = 0;
			while (counted < WORDS_PER_SEG) begin
				if ($urandom_range(99) < ((board.count < cscan_pkg::MAX_REQUESTS) ? 35 : 8))
				begin
					// mostly ascending requests, some out of order
					if ($urandom_range(9) == 0) begin
						head = $urandom_range(4095);
					end else begin
						next_track += $urandom_range(150);
						if (next_track > 4095)
							next_track = 4095;
						head = next_track;
					end
					if (board.count < cscan_pkg::MAX_REQUESTS)
						counted++;
					send_word(make_word(cscan_pkg::KIND_LOAD, head, 1'($urandom_range(1))));
				end else begin
					// head near a stored request or anywhere
					if (board.count > 0 && $urandom_range(1)) begin
						head = int'(board.store[$urandom_range(board.count - 1)]);
						head = head + int'($urandom_range(2)) - 1;
						if (head < 0)
							head = 0;
						if (head > 4095)
							head = 4095;
					end else begin
						head = $urandom_range(4095);
					end
					counted++;
					send_word(make_word(cscan_pkg::KIND_START, head, 1'($urandom_range(1))));
				end
			end
		end

		// drain and settle
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
